### rtl/fkin_pkg.sv
// Shared types and constants of the six-joint forward kinematics block.
// No dependencies; every other file of the block imports this package.
package fkin_pkg;

    localparam int JOINTS    = 6;
    localparam int ANGLE_W   = 17;
    localparam int LEN_W     = 18;
    localparam int POS_W     = 19;
    localparam int TRIG_W    = 18;
    localparam int VEC_W     = 22;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOREARM_LENGTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRIST_ONE_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRIST_TWO_OFFSET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRIST_THREE_OFFSET = 3'd5;

    typedef logic signed [LEN_W-1:0]  len_t;
    typedef len_t [JOINTS-1:0]        len_vec_t;
    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [VEC_W-1:0]  vec_t;

    typedef struct packed {
        trig_t s;
        trig_t c;
    } joint_sc_t;

    typedef joint_sc_t [JOINTS-1:0] sc_vec_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    // Reset values of the link lengths and offsets
    localparam len_t RST_BASE_OFFSET        = 18'sd10650;
    localparam len_t RST_UPPER_ARM_LENGTH   = -18'sd27853;
    localparam len_t RST_FOREARM_LENGTH     = -18'sd25703;
    localparam len_t RST_WRIST_ONE_OFFSET   = 18'sd8736;
    localparam len_t RST_WRIST_TWO_OFFSET   = 18'sd6534;
    localparam len_t RST_WRIST_THREE_OFFSET = 18'sd6527;

    // Fixed twist of each joint, sine and cosine in {-1, 0, 1}
    localparam int TWIST_SIN [JOINTS] = '{1, 0, 0, 1, -1, 0};
    localparam int TWIST_COS [JOINTS] = '{0, 1, 1, 0, 0, 1};

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Angle reduction, hundredths of a degree
    localparam int TWO_TURNS   = 72000;
    localparam int ONE_TURN    = 36000;
    localparam int QUARTER     = 9000;
    localparam int EIGHTH      = 4500;

    // Radian conversion: x = fold*X_INT_MUL + (fold*X_FRAC_MUL + X_BIAS) / X_DIV
    localparam logic [17:0] X_INT_MUL  = 18'd187403;
    localparam logic [12:0] X_FRAC_MUL = 13'd5426;
    localparam logic [24:0] X_BIAS     = 25'd9000;
    localparam logic [14:0] X_DIV      = 15'd18000;
    localparam logic [17:0] X_RCP      = 18'((64'h1_0000_0000) / 64'd18000);

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Horner steps: t = 1 - ((x2*t) >> 30) / D, division by reciprocal
    localparam int SIN_STEPS = 3;
    localparam int COS_STEPS = 4;
    localparam logic [5:0]  SIN_DIV [SIN_STEPS] = '{6'd42, 6'd20, 6'd6};
    localparam logic [31:0] SIN_RCP [SIN_STEPS] = '{
        32'((64'h1_0000_0000) / 64'd42),
        32'((64'h1_0000_0000) / 64'd20),
        32'((64'h1_0000_0000) / 64'd6)};
    localparam logic [5:0]  COS_DIV [COS_STEPS] = '{6'd56, 6'd30, 6'd12, 6'd2};
    localparam logic [31:0] COS_RCP [COS_STEPS] = '{
        32'((64'h1_0000_0000) / 64'd56),
        32'((64'h1_0000_0000) / 64'd30),
        32'((64'h1_0000_0000) / 64'd12),
        32'((64'h1_0000_0000) / 64'd2)};

    // Pipeline and queue sizes
    localparam int SINCOS_LAT  = 18;
    localparam int FRONT_LAT   = 3 + SINCOS_LAT;
    localparam int BACK_STAGES = 2 * JOINTS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam vec_t POS_MAX_V = 22'sd262143;
    localparam vec_t POS_MIN_V = -22'sd262144;

endpackage

### rtl/six_joint_forward_kinematics_top.sv
// Top level of the six-joint forward kinematics block: configuration registers
// and the front, queue and back parts. Depends on fkin_pkg and all fkin_ modules.
//
// Usage: one request on the s_axis channel carries six joint angles in hundredths
// of a degree; one result on the m_axis channel carries the end effector X, Y, Z
// position in 1/65536 m, saturated to 19 bits. Requests are independent.
// Throughput is one request per clock cycle while the queue has room. From an accepted
// request to m_axis_tvalid the data passes the front (angle reduction, 18-stage sine and
// cosine series), the four-entry queue, the joint chain (two stages per joint) and the
// output register.
// If m_axis_tready is low the result holds in the output register and the back
// stops; the front keeps running into the queue and drops s_axis_tready only when
// the queue fills.
// The cfg channel writes the link lengths and offsets by register index, one per
// cycle; cfg_ready is always high and an unknown index is ignored. Write only
// while no request is in flight.
// Reset (rst_n low) clears all valid flags and loads the default arm geometry.
module six_joint_forward_kinematics_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // joint1_angle .. joint6_angle, 17 bits each from bit 0, zero fill to 104
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [fkin_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // pos_x [18:0], pos_y [37:19], pos_z [56:38], zero fill to 64
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fkin_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fkin_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fkin_pkg::LEN_W-1:0]         cfg_data
);
    import fkin_pkg::*;

    len_vec_t  cfg_len_reg;
    q_status_t q_status;
    sc_vec_t   push_data;
    sc_vec_t   q_head;
    logic      push;
    logic      pop;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg[0] <= RST_BASE_OFFSET;
            cfg_len_reg[1] <= RST_UPPER_ARM_LENGTH;
            cfg_len_reg[2] <= RST_FOREARM_LENGTH;
            cfg_len_reg[3] <= RST_WRIST_ONE_OFFSET;
            cfg_len_reg[4] <= RST_WRIST_TWO_OFFSET;
            cfg_len_reg[5] <= RST_WRIST_THREE_OFFSET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BASE_OFFSET:        cfg_len_reg[0] <= cfg_data;
                REG_UPPER_ARM_LENGTH:   cfg_len_reg[1] <= cfg_data;
                REG_FOREARM_LENGTH:     cfg_len_reg[2] <= cfg_data;
                REG_WRIST_ONE_OFFSET:   cfg_len_reg[3] <= cfg_data;
                REG_WRIST_TWO_OFFSET:   cfg_len_reg[4] <= cfg_data;
                REG_WRIST_THREE_OFFSET: cfg_len_reg[5] <= cfg_data;
                default:                ;
            endcase
        end
    end

    fkin_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    fkin_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .status    (q_status),
        .head      (q_head)
    );

    fkin_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_head   (q_head),
        .pop      (pop),
        .lens     (cfg_len_reg),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata)
    );

endmodule

### rtl/fkin_sincos.sv
// Pipelined sine and cosine of one folded angle, Q1.16.
// Depends on fkin_pkg.
module fkin_sincos (
    input  logic                clk,
    input  logic                en,
    input  logic [12:0]         fold,
    input  logic                swap,
    input  logic [1:0]          quad,
    output fkin_pkg::trig_t     sin_q,
    output fkin_pkg::trig_t     cos_q
);
    import fkin_pkg::*;

    logic [24:0] w1_reg;
    logic [29:0] base1_reg;
    logic [42:0] m2_reg;
    logic [24:0] w2_reg;
    logic [29:0] base2_reg;
    logic [29:0] x3_reg;
    logic [59:0] xx4_reg;
    logic [29:0] x4_reg;
    logic [10:0] q0x;
    logic [24:0] remx;

    logic [29:0] cx2 [COS_STEPS];
    logic [30:0] ct  [COS_STEPS+1];
    logic [29:0] sx2 [SIN_STEPS];
    logic [30:0] st  [SIN_STEPS+1];
    logic [29:0] sx  [SIN_STEPS+1];

    logic [60:0] sp_reg;
    logic [16:0] s_rnd_reg;
    logic [16:0] s_d1_reg;
    logic [16:0] s_d2_reg;
    logic [16:0] c_rnd_reg;
    logic [31:0] c_sum;
    logic [30:0] s_sum;

    logic        swap_dly [SINCOS_LAT-1];
    logic [1:0]  quad_dly [SINCOS_LAT-1];

    trig_t s_oct;
    trig_t c_oct;
    trig_t sin_reg;
    trig_t cos_reg;
    trig_t sin_next;
    trig_t cos_next;

    // Convert hundredths of a degree to Q30 radians
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg    <= 25'(fold * X_FRAC_MUL) + X_BIAS;
            base1_reg <= 30'(fold * X_INT_MUL);
            m2_reg    <= w1_reg * X_RCP;
            w2_reg    <= w1_reg;
            base2_reg <= base1_reg;
            x3_reg    <= base2_reg + 30'(q0x) + ((remx >= 25'(X_DIV)) ? 30'd1 : 30'd0);
            xx4_reg   <= x3_reg * x3_reg;
            x4_reg    <= x3_reg;
        end
    end

    always_comb
    begin
        q0x  = m2_reg[42:32];
        remx = w2_reg - 25'(q0x * X_DIV);
    end

    assign cx2[0] = xx4_reg[59:30];
    assign ct[0]  = ONE_Q30;
    assign sx2[0] = xx4_reg[59:30];
    assign st[0]  = ONE_Q30;
    assign sx[0]  = x4_reg;

    // Cosine Horner chain
    for (genvar k = 0; k < COS_STEPS; k++)
    begin : g_cos
        logic [60:0] p_reg;
        logic [61:0] m_reg;
        logic [29:0] a_reg;
        logic [29:0] x2a_reg;
        logic [29:0] x2b_reg;
        logic [30:0] t_reg;
        logic [29:0] q0;
        logic [29:0] rem;
        logic [29:0] q;

        always_comb
        begin
            q0  = m_reg[61:32];
            rem = a_reg - 30'(q0 * COS_DIV[k]);
            q   = q0 + ((rem >= 30'(COS_DIV[k])) ? 30'd1 : 30'd0);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg   <= cx2[k] * ct[k];
                x2a_reg <= cx2[k];
                m_reg   <= p_reg[59:30] * COS_RCP[k];
                a_reg   <= p_reg[59:30];
                x2b_reg <= x2a_reg;
                t_reg   <= ONE_Q30 - {1'b0, q};
            end
        end

        assign ct[k+1] = t_reg;

        if (k < COS_STEPS - 1)
        begin : g_carry
            logic [29:0] x2c_reg;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x2c_reg <= x2b_reg;
                end
            end
            assign cx2[k+1] = x2c_reg;
        end
    end

    // Sine Horner chain, carries x for the final product
    for (genvar k = 0; k < SIN_STEPS; k++)
    begin : g_sin
        logic [60:0] p_reg;
        logic [61:0] m_reg;
        logic [29:0] a_reg;
        logic [29:0] x2a_reg;
        logic [29:0] x2b_reg;
        logic [29:0] xa_reg;
        logic [29:0] xb_reg;
        logic [29:0] xc_reg;
        logic [30:0] t_reg;
        logic [29:0] q0;
        logic [29:0] rem;
        logic [29:0] q;

        always_comb
        begin
            q0  = m_reg[61:32];
            rem = a_reg - 30'(q0 * SIN_DIV[k]);
            q   = q0 + ((rem >= 30'(SIN_DIV[k])) ? 30'd1 : 30'd0);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg   <= sx2[k] * st[k];
                x2a_reg <= sx2[k];
                xa_reg  <= sx[k];
                m_reg   <= p_reg[59:30] * SIN_RCP[k];
                a_reg   <= p_reg[59:30];
                x2b_reg <= x2a_reg;
                xb_reg  <= xa_reg;
                t_reg   <= ONE_Q30 - {1'b0, q};
                xc_reg  <= xb_reg;
            end
        end

        assign st[k+1] = t_reg;
        assign sx[k+1] = xc_reg;

        if (k < SIN_STEPS - 1)
        begin : g_carry
            logic [29:0] x2c_reg;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x2c_reg <= x2b_reg;
                end
            end
            assign sx2[k+1] = x2c_reg;
        end
    end

    // Round both results to Q1.16 and align the sine to the cosine
    always_comb
    begin
        s_sum = {1'b0, sp_reg[59:30]} + 31'd8192;
        c_sum = {1'b0, ct[COS_STEPS]} + 32'd8192;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg    <= sx[SIN_STEPS] * st[SIN_STEPS];
            s_rnd_reg <= s_sum[30:14];
            s_d1_reg  <= s_rnd_reg;
            s_d2_reg  <= s_d1_reg;
            c_rnd_reg <= c_sum[30:14];
        end
    end

    // Delay fold and quadrant bits alongside the series
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            swap_dly[0] <= swap;
            quad_dly[0] <= quad;
            for (int i = 1; i < SINCOS_LAT - 1; i++)
            begin
                swap_dly[i] <= swap_dly[i-1];
                quad_dly[i] <= quad_dly[i-1];
            end
        end
    end

    // Undo the octant fold, then apply the quadrant
    always_comb
    begin
        if (swap_dly[SINCOS_LAT-2])
        begin
            s_oct = trig_t'({1'b0, c_rnd_reg});
            c_oct = trig_t'({1'b0, s_d2_reg});
        end
        else
        begin
            s_oct = trig_t'({1'b0, s_d2_reg});
            c_oct = trig_t'({1'b0, c_rnd_reg});
        end
        unique case (quad_dly[SINCOS_LAT-2])
            QUAD_0:
            begin
                sin_next = s_oct;
                cos_next = c_oct;
            end
            QUAD_1:
            begin
                sin_next = c_oct;
                cos_next = -s_oct;
            end
            QUAD_2:
            begin
                sin_next = -s_oct;
                cos_next = -c_oct;
            end
            default:
            begin
                sin_next = -c_oct;
                cos_next = s_oct;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

### rtl/fkin_front.sv
// Front part: accepts angle requests, reduces each angle and computes its sine and cosine.
// Depends on fkin_pkg and fkin_sincos.
module fkin_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fkin_pkg::IN_DATA_W-1:0] s_tdata,
    input  fkin_pkg::q_status_t           q_status,
    output logic                          push,
    output fkin_pkg::sc_vec_t             push_data
);
    import fkin_pkg::*;

    logic                 en;
    logic [FRONT_LAT-1:0] valid_reg;
    logic [FRONT_LAT-1:0] valid_next;

    // Advance the whole front whenever the queue has room
    assign en       = !q_status.full;
    assign s_tready = en;
    assign push     = en && valid_reg[FRONT_LAT-1];

    always_comb
    begin
        valid_next = {valid_reg[FRONT_LAT-2:0], s_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar j = 0; j < JOINTS; j++)
    begin : g_joint
        logic signed [ANGLE_W-1:0] ang_reg;
        logic signed [18:0]        lifted;
        logic [16:0]               b1_reg;
        logic [16:0]               b1_next;
        logic [15:0]               b2;
        logic [13:0]               u;
        logic [1:0]                quad_next;
        logic [12:0]               fold_reg;
        logic [12:0]               fold_next;
        logic                      swap_reg;
        logic [1:0]                quad_reg;

        // Wrap the angle into one turn in two steps
        always_comb
        begin
            lifted  = 19'(ang_reg) + 19'(TWO_TURNS);
            b1_next = (lifted >= 19'(TWO_TURNS)) ? 17'(lifted - 19'(TWO_TURNS))
                                                 : 17'(lifted);
            b2 = (b1_reg >= 17'(ONE_TURN)) ? 16'(b1_reg - 17'(ONE_TURN)) : 16'(b1_reg);
            if (b2 >= 16'(3 * QUARTER))
            begin
                quad_next = QUAD_3;
                u         = 14'(b2 - 16'(3 * QUARTER));
            end
            else if (b2 >= 16'(2 * QUARTER))
            begin
                quad_next = QUAD_2;
                u         = 14'(b2 - 16'(2 * QUARTER));
            end
            else if (b2 >= 16'(QUARTER))
            begin
                quad_next = QUAD_1;
                u         = 14'(b2 - 16'(QUARTER));
            end
            else
            begin
                quad_next = QUAD_0;
                u         = 14'(b2);
            end
            fold_next = (u > 14'(EIGHTH)) ? 13'(14'(QUARTER) - u) : 13'(u);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ang_reg  <= s_tdata[j*ANGLE_W +: ANGLE_W];
                b1_reg   <= b1_next;
                fold_reg <= fold_next;
                swap_reg <= (u > 14'(EIGHTH));
                quad_reg <= quad_next;
            end
        end

        fkin_sincos u_sincos (
            .clk   (clk),
            .en    (en),
            .fold  (fold_reg),
            .swap  (swap_reg),
            .quad  (quad_reg),
            .sin_q (push_data[j].s),
            .cos_q (push_data[j].c)
        );
    end

endmodule

### rtl/fkin_queue.sv
// Short queue of sine/cosine sets between the front and the back part.
// Depends on fkin_pkg.
module fkin_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fkin_pkg::sc_vec_t   push_data,
    input  logic                pop,
    output fkin_pkg::q_status_t status,
    output fkin_pkg::sc_vec_t   head
);
    import fkin_pkg::*;

    sc_vec_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.valid = (count_reg != '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/fkin_back.sv
// Back part: chains the six joint transforms and registers the saturated position.
// Depends on fkin_pkg.
module fkin_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fkin_pkg::q_status_t             q_status,
    input  fkin_pkg::sc_vec_t               q_head,
    output logic                            pop,
    input  fkin_pkg::len_vec_t              lens,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fkin_pkg::OUT_DATA_W-1:0] m_tdata
);
    import fkin_pkg::*;

    logic                   ben;
    logic [BACK_STAGES-1:0] valid_reg;
    logic                   out_valid_reg;
    logic [POS_W-1:0]       px_out_reg;
    logic [POS_W-1:0]       py_out_reg;
    logic [POS_W-1:0]       pz_out_reg;

    sc_vec_t sc_in [JOINTS+1];
    vec_t    vx_in [JOINTS+1];
    vec_t    vy_in [JOINTS+1];
    vec_t    vz_in [JOINTS+1];

    function automatic logic [POS_W-1:0] sat_pos(input vec_t v);
        logic [POS_W-1:0] r;
        if (v > POS_MAX_V)
        begin
            r = POS_W'(POS_MAX_V);
        end
        else if (v < POS_MIN_V)
        begin
            r = POS_W'(POS_MIN_V);
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // Hold the chain while a finished result waits
    assign ben = !out_valid_reg || m_tready;
    assign pop = ben && q_status.valid;

    assign sc_in[0] = q_head;
    assign vx_in[0] = '0;
    assign vy_in[0] = '0;
    assign vz_in[0] = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ben)
        begin
            valid_reg     <= {valid_reg[BACK_STAGES-2:0], q_status.valid};
            out_valid_reg <= valid_reg[BACK_STAGES-1];
        end
    end

    // One joint per two stages, last joint first
    for (genvar j = 0; j < JOINTS; j++)
    begin : g_step
        localparam int N = JOINTS - 1 - j;

        logic signed [VEC_W:0]   px;
        logic signed [VEC_W:0]   qv;
        logic signed [VEC_W:0]   zb;
        logic signed [VEC_W:0]   reach;
        logic signed [VEC_W:0]   lift;
        logic signed [40:0]      cpx_reg;
        logic signed [40:0]      spx_reg;
        logic signed [40:0]      cq_reg;
        logic signed [40:0]      sq_reg;
        vec_t                    nz_reg;
        sc_vec_t                 sc1_reg;
        logic signed [41:0]      sumx;
        logic signed [41:0]      sumy;
        vec_t                    vx_reg;
        vec_t                    vy_reg;
        vec_t                    vz_reg;
        sc_vec_t                 sc2_reg;

        // Link length feeds x, link offset feeds z
        always_comb
        begin
            if (N == 1 || N == 2)
            begin
                reach = (VEC_W+1)'(lens[N]);
                lift  = '0;
            end
            else
            begin
                reach = '0;
                lift  = (VEC_W+1)'(lens[N]);
            end
            px = (VEC_W+1)'(vx_in[j]) + reach;
            if (TWIST_COS[N] == 1)
            begin
                qv = (VEC_W+1)'(vy_in[j]);
                zb = (VEC_W+1)'(vz_in[j]);
            end
            else if (TWIST_SIN[N] == 1)
            begin
                qv = -(VEC_W+1)'(vz_in[j]);
                zb = (VEC_W+1)'(vy_in[j]);
            end
            else
            begin
                qv = (VEC_W+1)'(vz_in[j]);
                zb = -(VEC_W+1)'(vy_in[j]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (ben)
            begin
                cpx_reg <= sc_in[j][N].c * px;
                spx_reg <= sc_in[j][N].s * px;
                cq_reg  <= sc_in[j][N].c * qv;
                sq_reg  <= sc_in[j][N].s * qv;
                nz_reg  <= VEC_W'(zb + lift);
                sc1_reg <= sc_in[j];
            end
        end

        // Rotate and round to 1/65536 m
        always_comb
        begin
            sumx = 42'(cpx_reg) - 42'(sq_reg) + 42'sd32768;
            sumy = 42'(spx_reg) + 42'(cq_reg) + 42'sd32768;
        end

        always_ff @(posedge clk)
        begin
            if (ben)
            begin
                vx_reg  <= sumx[16 +: VEC_W];
                vy_reg  <= sumy[16 +: VEC_W];
                vz_reg  <= nz_reg;
                sc2_reg <= sc1_reg;
            end
        end

        assign vx_in[j+1] = vx_reg;
        assign vy_in[j+1] = vy_reg;
        assign vz_in[j+1] = vz_reg;
        assign sc_in[j+1] = sc2_reg;
    end

    // Saturate into the output register
    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            px_out_reg <= sat_pos(vx_in[JOINTS]);
            py_out_reg <= sat_pos(vy_in[JOINTS]);
            pz_out_reg <= sat_pos(vz_in[JOINTS]);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - 3*POS_W)'(0), pz_out_reg, py_out_reg, px_out_reg};

endmodule

### sim/tb.sv
// Testbench for six_joint_forward_kinematics_top: random and directed joint poses,
// checked against a fixed-point kinematics predictor. Depends on fkin_pkg and the RTL.
module tb;
    import fkin_pkg::*;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef angle_t pose_t [JOINTS];

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } tip_pos_t;

    // Expected tip positions and the arm geometry they are computed from
    class pose_scoreboard;
        tip_pos_t tip_q[$];
        longint   link_len[JOINTS];
        int       mismatches;

        function new();
            link_len = '{10650, -27853, -25703, 8736, 6534, 6527};
            mismatches = 0;
        endfunction

        function void set_length(logic [CFG_IDX_W-1:0] idx, logic signed [LEN_W-1:0] val);
            if (idx <= REG_WRIST_THREE_OFFSET)
                link_len[idx] = longint'(val);
        endfunction

        // Sine and cosine of 0..45 degrees, Q1.16, from a Q30 Horner series
        function void octant_trig(longint u, output longint s, output longint c);
            bit [63:0] x, x2, t;
            x  = (64'(u) * 64'd3373259426 + 64'd9000) / 64'd18000;
            x2 = (x * x) >> 30;
            t = 64'd1073741824 - x2 / 64'd42;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
            s = longint'((((x * t) >> 30) + 64'd8192) >> 14);
            t = 64'd1073741824 - x2 / 64'd56;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd30;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd12;
            t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd2;
            c = longint'((t + 64'd8192) >> 14);
        endfunction

        function void joint_trig(angle_t ang, output longint s, output longint c);
            longint a, u, s0, c0;
            a = ((longint'(ang) % 36000) + 36000) % 36000;
            u = a % 9000;
            if (u <= 4500)
                octant_trig(u, s0, c0);
            else
                octant_trig(9000 - u, c0, s0);
            case (a / 9000)
                0: begin s = s0;  c = c0;  end
                1: begin s = c0;  c = -s0; end
                2: begin s = -s0; c = -c0; end
                default: begin s = -c0; c = s0; end
            endcase
        endfunction

        function logic signed [POS_W-1:0] clamp_pos(longint v);
            if (v > 262143)
                v = 262143;
            if (v < -262144)
                v = -262144;
            return v[POS_W-1:0];
        endfunction

        // Walk the chain from the wrist back to the base
        function tip_pos_t tip_position(pose_t pose);
            longint vx, vy, vz, s, c, reach, lift, px, q, nx, ny;
            tip_pos_t r;
            vx = 0; vy = 0; vz = 0;
            for (int n = JOINTS - 1; n >= 0; n--)
            begin
                joint_trig(pose[n], s, c);
                reach = (n == 1 || n == 2) ? link_len[n] : 0;
                lift  = (n == 1 || n == 2) ? 0 : link_len[n];
                px = vx + reach;
                q  = TWIST_COS[n] * vy - TWIST_SIN[n] * vz;
                nx = (c * px - s * q + 32768) >>> 16;
                ny = (s * px + c * q + 32768) >>> 16;
                vz = TWIST_SIN[n] * vy + TWIST_COS[n] * vz + lift;
                vx = nx;
                vy = ny;
            end
            r.x = clamp_pos(vx);
            r.y = clamp_pos(vy);
            r.z = clamp_pos(vz);
            return r;
        endfunction

        function void note_request(logic [IN_DATA_W-1:0] data);
            pose_t pose;
            for (int j = 0; j < JOINTS; j++)
                pose[j] = data[j*ANGLE_W +: ANGLE_W];
            tip_q.push_back(tip_position(pose));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            tip_pos_t e, a;
            a.x = data[18:0];
            a.y = data[37:19];
            a.z = data[56:38];
            if (tip_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d", a.x, a.y, a.z);
                return;
            end
            e = tip_q.pop_front();
            if (a.x !== e.x || a.y !== e.y || a.z !== e.z)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                             e.x, e.y, e.z, a.x, a.y, a.z);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_W-1:0]     s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [LEN_W-1:0]         cfg_data;

    pose_scoreboard sb;
    int  sent_count;
    bit  calm;
    int  idle_cycles;

    six_joint_forward_kinematics_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sent_count = 0;
        calm = 1'b0;
        idle_cycles = 0;
        sb = new();
    end

    always #5 clk = ~clk;

    // Note accepted requests and check accepted results
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Watchdog: stop when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, none near the end
    initial
    begin
        bit held;
        int n;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sent_count >= 300)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n - 1) @(posedge clk);
        end
    end

    function automatic angle_t pick_angle();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return angle_t'($urandom);
        if (k == 1)
            return angle_t'(9000 * $urandom_range(0, 8) - 36000 + $urandom_range(0, 2) - 1);
        return angle_t'($urandom_range(0, 72000) - 36000);
    endfunction

    // Offer one request, with an optional gap, and hold it until accepted
    task automatic send_pose(pose_t pose);
        logic [IN_DATA_W-1:0] d;
        int gap;
        d = '0;
        for (int j = 0; j < JOINTS; j++)
            d[j*ANGLE_W +: ANGLE_W] = pose[j];
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_random_poses(int count);
        pose_t pose;
        for (int i = 0; i < count; i++)
        begin
            for (int j = 0; j < JOINTS; j++)
                pose[j] = pick_angle();
            send_pose(pose);
        end
    endtask

    // Drain all results, then let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.tip_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write one register, then drop valid for a cycle
    task automatic write_length(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        sb.set_length(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_lengths(logic [LEN_W-1:0] val, bit rand_each);
        for (int r = 0; r < JOINTS; r++)
            write_length(CFG_IDX_W'(r), rand_each ? LEN_W'($urandom) : val);
    endtask

    initial
    begin
        pose_t pose;
        int special [10];
        special = '{0, 36000, -36000, 9000, -9000, 4500, 4501, 13500, -65536, 65535};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each joint swept through the special angles, default geometry
        for (int k = 0; k < 10; k++)
        begin
            for (int j = 0; j < JOINTS; j++)
                pose[j] = angle_t'(special[(k + j) % 10]);
            send_pose(pose);
        end
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < JOINTS; j++)
                pose[j] = angle_t'(k[0] ? 8999 + 18000 * j : -4499 - 9000 * k);
            send_pose(pose);
        end
        wait_idle();

        // Unknown indexes must leave the geometry alone
        write_length(3'd6, LEN_W'(131071));
        write_length(3'd7, LEN_W'(-131072));
        send_random_poses(20);
        wait_idle();

        // Largest and smallest lengths drive the outputs into saturation
        write_all_lengths(LEN_W'(131071), 1'b0);
        send_random_poses(100);
        wait_idle();
        write_all_lengths(LEN_W'(-131072), 1'b0);
        send_random_poses(100);
        wait_idle();

        // Random geometries
        for (int p = 0; p < 3; p++)
        begin
            write_all_lengths('0, 1'b1);
            send_random_poses(110);
            wait_idle();
        end

        // Back to defaults, then the last requests at full rate with no stalls
        write_length(REG_BASE_OFFSET,        RST_BASE_OFFSET);
        write_length(REG_UPPER_ARM_LENGTH,   RST_UPPER_ARM_LENGTH);
        write_length(REG_FOREARM_LENGTH,     RST_FOREARM_LENGTH);
        write_length(REG_WRIST_ONE_OFFSET,   RST_WRIST_ONE_OFFSET);
        write_length(REG_WRIST_TWO_OFFSET,   RST_WRIST_TWO_OFFSET);
        write_length(REG_WRIST_THREE_OFFSET, RST_WRIST_THREE_OFFSET);
        send_random_poses(60);
        calm = 1'b1;
        send_random_poses(60);
        wait_idle();

        if (sb.mismatches == 0 && sb.tip_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
